// ----- rtl/core/protobuf_report_field_extractor_top_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef PROTOBUF_REPORT_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define PROTOBUF_REPORT_FIELD_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define PFE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under synchronous reset.
`define PFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pfe_pkg.sv -----
package pfe_pkg;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VALUE,
      PH_LEN,
      PH_SKIP,
      PH_TEXT,
      PH_HALT
   } pfe_phase_type;

   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN     = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;
   localparam logic [2:0] WIRE_MASK    = 3'h7;

   localparam logic [7:0] FIELD_MODEL_REPORT = 8'd3;
   localparam logic [7:0] FIELD_TEXT         = 8'd4;
   localparam logic [7:0] FIELD_MODEL_NODE   = 8'd6;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_NODE   = 1'b1;

   localparam logic [7:0] PRINT_LO = 8'd32;
   localparam logic [7:0] PRINT_HI = 8'd126;

   localparam logic [31:0] FIXED64_BYTES = 32'd8;
   localparam logic [31:0] FIXED32_BYTES = 32'd4;

   // varint bytes whose 7-bit groups still land inside the 32-bit accumulator
   localparam int VARINT_ACC_BYTES = 5;
   localparam int VARINT_GROUP     = 7;

   localparam int RUN_W     = 5;
   localparam int RUN_CAP   = 31;
   localparam int LEN_WIDE_W = 9;

   typedef struct packed {
      logic [31:0]      model_code;
      logic             model_seen;
      logic [RUN_W-1:0] text_length;
      logic             text_empty;
      logic [RUN_W-1:0] last_index;
      logic             bank_sel;
   } pfe_run_type;

endpackage

// ----- rtl/core/pfe_if.sv -----
interface pfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       record_kind;
   logic       last_byte;

   modport source (output valid, output payload_byte, output record_kind,
                   output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input record_kind,
                   input last_byte, output ready);
endinterface

interface pfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] model_code;
   logic        model_seen;
   logic [4:0]  text_length;
   logic [7:0]  text_char;
   logic [4:0]  text_index;
   logic        run_end;

   modport source (output valid, output model_code, output model_seen,
                   output text_length, output text_char, output text_index,
                   output run_end, input ready);
   modport sink   (input valid, input model_code, input model_seen,
                   input text_length, input text_char, input text_index,
                   input run_end, output ready);
endinterface

// ----- rtl/core/pfe_text_store.sv -----
module pfe_text_store #(
   parameter int TEXT_MAX = 31
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic                                   wr_bank,
   input  logic [((TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1)-1:0] wr_idx,
   input  logic [7:0]                             wr_data,
   input  logic                                   rd_bank,
   input  logic [pfe_pkg::RUN_W-1:0]              rd_idx,
   output logic [7:0]                             rd_data
);

   localparam int IdxW  = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int Depth = 2 * TEXT_MAX;
   localparam int AddrW = $clog2(Depth);

   logic [7:0]       text_mem [Depth];
   logic [7:0]       rd_data_ff;
   logic [AddrW-1:0] wr_addr;
   logic [AddrW-1:0] rd_addr;

   // bank 1 sits above bank 0
   assign wr_addr = AddrW'(wr_bank ? TEXT_MAX : 0) + AddrW'(wr_idx);
   assign rd_addr = AddrW'(rd_bank ? TEXT_MAX : 0) + AddrW'(IdxW'(rd_idx));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_mem[wr_addr] <= wr_data;
      end
      // forward a word written at the same edge
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= text_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pfe_parser.sv -----
module pfe_parser #(
   parameter int TEXT_MAX         = 31,
   parameter int VARINT_MAX_BYTES = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_take,
   input  logic [7:0]                  payload_byte,
   input  logic                        record_kind,
   input  logic                        last_byte,
   output logic                        wr_en,
   output logic                        wr_bank,
   output logic [((TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1)-1:0] wr_idx,
   output logic [7:0]                  wr_data,
   output logic                        run_load,
   output pfe_pkg::pfe_run_type        run_info
);

   localparam int IdxW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int LenW = $clog2(TEXT_MAX + 1);
   localparam int VbW  = $clog2(VARINT_MAX_BYTES + 1);

   pfe_pkg::pfe_phase_type phase_ff, phase_in;
   logic [31:0]     accum_ff, accum_in;
   logic [VbW-1:0]  vbytes_ff, vbytes_in;
   logic [7:0]      field_ff, field_in;
   logic [31:0]     skip_ff, skip_in;
   logic [LenW-1:0] cand_len_ff, cand_len_in;
   logic            cand_ok_ff, cand_ok_in;
   logic [LenW-1:0] comm_len_ff, comm_len_in;
   logic [31:0]     model_ff, model_in;
   logic            seen_ff, seen_in;
   logic            kind_ff, kind_in;
   logic            start_ff, start_in;
   logic            bank_ff, bank_in;

   logic [31:0]             acc_now;
   logic [VbW-1:0]          vb_inc;
   logic [31:0]             skip_dec;
   logic [4:0]              grp_shift;
   logic                    printable;
   logic [pfe_pkg::LEN_WIDE_W-1:0] len_wide;

   assign grp_shift = 5'(vbytes_ff) * 5'(pfe_pkg::VARINT_GROUP);
   assign vb_inc    = vbytes_ff + VbW'(1);
   assign skip_dec  = skip_ff - 32'd1;
   assign printable = (payload_byte >= pfe_pkg::PRINT_LO) &&
                      (payload_byte <= pfe_pkg::PRINT_HI);

   always_comb begin
      if (vbytes_ff < VbW'(pfe_pkg::VARINT_ACC_BYTES)) begin
         acc_now = accum_ff | (32'(payload_byte[6:0]) << grp_shift);
      end else begin
         acc_now = accum_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      vbytes_in   = vbytes_ff;
      field_in    = field_ff;
      skip_in     = skip_ff;
      cand_len_in = cand_len_ff;
      cand_ok_in  = cand_ok_ff;
      comm_len_in = comm_len_ff;
      model_in    = model_ff;
      seen_in     = seen_ff;
      kind_in     = kind_ff;
      start_in    = start_ff;
      bank_in     = bank_ff;
      wr_en       = 1'b0;

      if (byte_take) begin
         if (start_ff) begin
            kind_in = record_kind;
         end
         start_in = 1'b0;

         case (phase_ff)
            pfe_pkg::PH_TAG, pfe_pkg::PH_VALUE, pfe_pkg::PH_LEN: begin
               if (payload_byte[7]) begin
                  accum_in  = acc_now;
                  vbytes_in = vb_inc;
                  if (vb_inc >= VbW'(VARINT_MAX_BYTES)) begin
                     phase_in = pfe_pkg::PH_HALT;
                  end
               end else begin
                  accum_in  = '0;
                  vbytes_in = '0;
                  case (phase_ff)
                     pfe_pkg::PH_TAG: begin
                        field_in = acc_now[10:3];
                        case (acc_now[2:0] & pfe_pkg::WIRE_MASK)
                           pfe_pkg::WIRE_VARINT: phase_in = pfe_pkg::PH_VALUE;
                           pfe_pkg::WIRE_LEN:    phase_in = pfe_pkg::PH_LEN;
                           pfe_pkg::WIRE_FIXED64: begin
                              skip_in  = pfe_pkg::FIXED64_BYTES;
                              phase_in = pfe_pkg::PH_SKIP;
                           end
                           pfe_pkg::WIRE_FIXED32: begin
                              skip_in  = pfe_pkg::FIXED32_BYTES;
                              phase_in = pfe_pkg::PH_SKIP;
                           end
                           default: phase_in = pfe_pkg::PH_HALT;
                        endcase
                     end
                     pfe_pkg::PH_VALUE: begin
                        phase_in = pfe_pkg::PH_TAG;
                        if (kind_in == pfe_pkg::KIND_REPORT &&
                            field_ff == pfe_pkg::FIELD_MODEL_REPORT) begin
                           model_in = acc_now;
                           seen_in  = 1'b1;
                        end else if (kind_in == pfe_pkg::KIND_NODE &&
                                     field_ff == pfe_pkg::FIELD_MODEL_NODE) begin
                           model_in = acc_now;
                           seen_in  = 1'b1;
                           phase_in = pfe_pkg::PH_HALT;
                        end
                     end
                     default: begin
                        skip_in = acc_now;
                        if (kind_in == pfe_pkg::KIND_REPORT &&
                            field_ff == pfe_pkg::FIELD_TEXT) begin
                           cand_len_in = '0;
                           cand_ok_in  = 1'b1;
                           phase_in    = (acc_now == 32'd0) ? pfe_pkg::PH_TAG
                                                            : pfe_pkg::PH_TEXT;
                        end else begin
                           phase_in = (acc_now == 32'd0) ? pfe_pkg::PH_TAG
                                                         : pfe_pkg::PH_SKIP;
                        end
                     end
                  endcase
               end
            end
            pfe_pkg::PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = pfe_pkg::PH_TAG;
               end
            end
            pfe_pkg::PH_TEXT: begin
               if (cand_len_ff < LenW'(TEXT_MAX)) begin
                  wr_en       = 1'b1;
                  cand_ok_in  = cand_ok_ff && printable;
                  cand_len_in = cand_len_ff + LenW'(1);
               end
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  // commit: the candidate bank becomes the committed one
                  if (cand_ok_in && cand_len_in != '0) begin
                     comm_len_in = cand_len_in;
                     bank_in     = ~bank_ff;
                  end
                  phase_in = pfe_pkg::PH_TAG;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_bank = ~bank_ff;
   assign wr_idx  = IdxW'(cand_len_ff);
   assign wr_data = payload_byte;

   assign run_load = byte_take && last_byte;
   assign len_wide = pfe_pkg::LEN_WIDE_W'(comm_len_in);

   always_comb begin
      run_info.model_code  = model_in;
      run_info.model_seen  = seen_in;
      run_info.text_length = pfe_pkg::RUN_W'(comm_len_in);
      run_info.text_empty  = (comm_len_in == '0);
      run_info.bank_sel    = bank_in;
      if (len_wide == '0) begin
         run_info.last_index = '0;
      end else if (len_wide > pfe_pkg::LEN_WIDE_W'(pfe_pkg::RUN_CAP)) begin
         run_info.last_index = pfe_pkg::RUN_W'(pfe_pkg::RUN_CAP - 1);
      end else begin
         run_info.last_index = pfe_pkg::RUN_W'(len_wide - pfe_pkg::LEN_WIDE_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= pfe_pkg::PH_TAG;
         accum_ff    <= '0;
         vbytes_ff   <= '0;
         field_ff    <= '0;
         skip_ff     <= '0;
         cand_len_ff <= '0;
         cand_ok_ff  <= 1'b1;
         comm_len_ff <= '0;
         model_ff    <= '0;
         seen_ff     <= 1'b0;
         kind_ff     <= 1'b0;
         start_ff    <= 1'b1;
         bank_ff     <= 1'b0;
      end else if (run_load) begin
         // end of payload: drop per-payload state, keep kind and bank
         phase_ff    <= pfe_pkg::PH_TAG;
         accum_ff    <= '0;
         vbytes_ff   <= '0;
         field_ff    <= '0;
         skip_ff     <= '0;
         cand_len_ff <= '0;
         cand_ok_ff  <= 1'b1;
         comm_len_ff <= '0;
         model_ff    <= '0;
         seen_ff     <= 1'b0;
         kind_ff     <= kind_in;
         start_ff    <= 1'b1;
         bank_ff     <= bank_in;
      end else begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         vbytes_ff   <= vbytes_in;
         field_ff    <= field_in;
         skip_ff     <= skip_in;
         cand_len_ff <= cand_len_in;
         cand_ok_ff  <= cand_ok_in;
         comm_len_ff <= comm_len_in;
         model_ff    <= model_in;
         seen_ff     <= seen_in;
         kind_ff     <= kind_in;
         start_ff    <= start_in;
         bank_ff     <= bank_in;
      end
   end

endmodule

// ----- rtl/core/pfe_run_gen.sv -----
module pfe_run_gen (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_load,
   input  pfe_pkg::pfe_run_type          run_info,
   input  logic [7:0]                    rd_data,
   output logic                          rd_bank,
   output logic [pfe_pkg::RUN_W-1:0]     rd_idx,
   output logic                          in_ready,
   pfe_rsp_if.source                     rsp_ch
);

   logic                         active_ff, active_in;
   logic [pfe_pkg::RUN_W-1:0]    idx_ff, idx_in;
   pfe_pkg::pfe_run_type         run_ff, run_in;
   logic                         at_end;
   logic                         step;

   assign at_end   = (idx_ff == run_ff.last_index);
   assign step     = active_ff && rsp_ch.ready;
   assign in_ready = !active_ff || (step && at_end);

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      run_in    = run_ff;
      if (run_load) begin
         active_in = 1'b1;
         idx_in    = '0;
         run_in    = run_info;
      end else if (step) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + pfe_pkg::RUN_W'(1);
         end
      end
   end

   // fetch the character for the word shown next cycle
   assign rd_bank = run_in.bank_sel;
   assign rd_idx  = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      run_ff <= run_in;
   end

   assign rsp_ch.valid       = active_ff;
   assign rsp_ch.model_code  = run_ff.model_code;
   assign rsp_ch.model_seen  = run_ff.model_seen;
   assign rsp_ch.text_length = run_ff.text_length;
   assign rsp_ch.text_char   = run_ff.text_empty ? 8'd0 : rd_data;
   assign rsp_ch.text_index  = idx_ff;
   assign rsp_ch.run_end     = at_end;

endmodule

// ----- rtl/core/protobuf_report_field_extractor_top.sv -----
// Protobuf report field extractor. One payload byte is taken per cycle on
// req_ch while req_ch.ready is high. The parser state (tag/value varints,
// skips, firmware text capture) updates in that same cycle, so bytes can
// follow back to back. The byte marked last_byte starts a run of
// max(1, committed length) result words, capped at 31, on rsp_ch. The first
// word shows in the next cycle, and the run advances one word per cycle while
// rsp_ch.ready is high. req_ch.ready is low while a run is shown. It returns in
// the cycle the final word of the run is taken, so the input also stays held
// while rsp_ch.ready is low. A single-word run that is taken at once does not
// hold the input.
// The firmware text lives in a two-bank memory with a registered read port;
// a commit swaps banks, so no copy is made and no clearing pass is needed.
module protobuf_report_field_extractor_top #(
   parameter int TEXT_MAX         = 31,
   parameter int VARINT_MAX_BYTES = 5
) (
   input  logic      clock,
   input  logic      reset,
   pfe_req_if.sink   req_ch,
   pfe_rsp_if.source rsp_ch
);

   localparam int IdxW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

   logic                      byte_take;
   logic                      in_ready;
   logic                      wr_en;
   logic                      wr_bank;
   logic [IdxW-1:0]           wr_idx;
   logic [7:0]                wr_data;
   logic                      run_load;
   pfe_pkg::pfe_run_type      run_info;
   logic                      rd_bank;
   logic [pfe_pkg::RUN_W-1:0] rd_idx;
   logic [7:0]                rd_data;

   assign req_ch.ready = in_ready;
   assign byte_take    = req_ch.valid && in_ready;

   pfe_parser #(
      .TEXT_MAX         (TEXT_MAX),
      .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (byte_take),
      .payload_byte (req_ch.payload_byte),
      .record_kind  (req_ch.record_kind),
      .last_byte    (req_ch.last_byte),
      .wr_en        (wr_en),
      .wr_bank      (wr_bank),
      .wr_idx       (wr_idx),
      .wr_data      (wr_data),
      .run_load     (run_load),
      .run_info     (run_info)
   );

   pfe_text_store #(
      .TEXT_MAX (TEXT_MAX)
   ) u_text (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_bank (wr_bank),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_bank (rd_bank),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   pfe_run_gen u_run (
      .clock    (clock),
      .reset    (reset),
      .run_load (run_load),
      .run_info (run_info),
      .rd_data  (rd_data),
      .rd_bank  (rd_bank),
      .rd_idx   (rd_idx),
      .in_ready (in_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- rtl/core/pfe_checker.sv -----
`include "protobuf_report_field_extractor_top_macros.svh"

module pfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] model_code,
   input logic        model_seen,
   input logic [4:0]  text_length,
   input logic [4:0]  text_index,
   input logic        run_end
);

   // a stalled word holds its place in the run
   `PFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(text_index), "stalled result word changed")

   // words of a run come in index order with no gap
   `PFE_ASSERT_NEXT(a_run_step, clock, reset, rsp_valid && rsp_ready && !run_end, rsp_valid && (text_index == $past(text_index) + 5'd1), "run index did not advance by one")

   // a run carries one model and one length throughout
   `PFE_ASSERT_NEXT(a_run_fields, clock, reset, rsp_valid && rsp_ready && !run_end, $stable(model_code) && $stable(model_seen) && $stable(text_length), "run fields changed mid-run")

   // no byte is taken while a run still has words after the current one
   `PFE_ASSERT_SAME(a_hold_input, clock, reset, rsp_valid && !run_end, !(req_valid && req_ready), "input accepted during a run")

endmodule

bind protobuf_report_field_extractor_top pfe_checker u_pfe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .model_code  (rsp_ch.model_code),
   .model_seen  (rsp_ch.model_seen),
   .text_length (rsp_ch.text_length),
   .text_index  (rsp_ch.text_index),
   .run_end     (rsp_ch.run_end)
);
